>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker file osss_check.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define OSSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// cond must never be true at a clock edge outside reset
`define OSSS_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/osss_pkg.sv
// ---------------------------------------------------------------------------
// osss_pkg
// Types and codes of the ordered integer set with successor search.
// ---------------------------------------------------------------------------
package osss_pkg;

	localparam int KEY_W          = 12;
	localparam int FUNC_W         = 3;
	localparam int STAT_W         = 2;
	localparam int SIZE_W         = 4;
	localparam int LEAF_W         = 64;
	localparam int BIT_W          = 6;
	localparam int KEY_LIMIT_LOG2 = 12;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(KEY_LIMIT_LOG2);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);

	localparam logic [FUNC_W-1:0] FN_INS  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DEL  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MEM  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SUCC = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PRED = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  neighbor;
	} out_t;

endpackage

>>> rtl/ordered_integer_set_successor_top.sv
// ---------------------------------------------------------------------------
// ordered_integer_set_successor_top
// Ordered integer set: insert, delete, member, successor, predecessor.
// ---------------------------------------------------------------------------
// The set lives in a single-port leaf memory of 64-bit words (key k is bit
// k%64 of word k/64) plus a summary register with one bit per nonempty word.
// One transaction is worked at a time. Insert, delete, member and every
// rejected request go through memory read, evaluate and write back, and
// output load, which waits while an earlier result is still unaccepted. A
// successor or predecessor that has to leave the key's own word adds a
// second read of the same memory port before the output load. The input is
// ready again in the cycle after the result enters the output register, so
// a result may wait there while the next transaction is taken. The summary
// bit of a word also serves as that word's valid flag, so reset needs no
// clearing pass and the block is ready right after reset. The size register
// is written only while the block is idle.
// ---------------------------------------------------------------------------
module ordered_integer_set_successor_top #(
	parameter int UNIVERSE_LOG2 = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  osss_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output osss_pkg::out_t              out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [osss_pkg::SIZE_W-1:0] cfg_data
);
	import osss_pkg::*;

	localparam int EFF_MAX = (UNIVERSE_LOG2 < KEY_LIMIT_LOG2) ? UNIVERSE_LOG2 : KEY_LIMIT_LOG2;
	localparam int WAW     = (EFF_MAX > BIT_W) ? EFF_MAX - BIT_W : 1;
	localparam int NWORDS  = 1 << WAW;
	localparam int FOUND_W = WAW + BIT_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LEAF = 4'b0010,
		S_NEXT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	function automatic logic [BIT_W-1:0] low_leaf(input logic [LEAF_W-1:0] v);
		logic [LEAF_W-1:0] iso;
		logic [BIT_W-1:0]  idx;
		iso = v & (~v + LEAF_W'(1));
		idx = '0;
		for (int i = 0; i < LEAF_W; i++) begin
			if (iso[i]) idx = idx | BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [BIT_W-1:0] high_leaf(input logic [LEAF_W-1:0] v);
		logic [LEAF_W-1:0] r;
		for (int i = 0; i < LEAF_W; i++) begin
			r[i] = v[LEAF_W-1-i];
		end
		return BIT_W'(LEAF_W - 1) - low_leaf(r);
	endfunction

	function automatic logic [WAW-1:0] low_sum(input logic [NWORDS-1:0] v);
		logic [NWORDS-1:0] iso;
		logic [WAW-1:0]    idx;
		iso = v & (~v + NWORDS'(1));
		idx = '0;
		for (int i = 0; i < NWORDS; i++) begin
			if (iso[i]) idx = idx | WAW'(i);
		end
		return idx;
	endfunction

	function automatic logic [WAW-1:0] high_sum(input logic [NWORDS-1:0] v);
		logic [NWORDS-1:0] r;
		for (int i = 0; i < NWORDS; i++) begin
			r[i] = v[NWORDS-1-i];
		end
		return WAW'(NWORDS - 1) - low_sum(r);
	endfunction

	state_t              state_q, state_d;
	logic [SIZE_W-1:0]   size_q;
	logic [FUNC_W-1:0]   func_q;
	logic [KEY_W-1:0]    key_q;
	logic [WAW-1:0]      wi_q;
	logic [LEAF_W-1:0]   rdata_q;
	logic [LEAF_W-1:0]   mem_q [NWORDS];
	logic [NWORDS-1:0]   summary_q;
	out_t                res_q, res_d;
	out_t                out_q;
	logic                out_valid_q;

	logic                in_acc;
	logic                load_out;
	logic [SIZE_W-1:0]   size_sat;
	logic [SIZE_W-1:0]   eff_log2;
	logic [KEY_W:0]      limit;
	logic                in_range;
	logic [WAW-1:0]      w;
	logic [BIT_W-1:0]    b;
	logic [LEAF_W-1:0]   bitm;
	logic [LEAF_W-1:0]   word;
	logic [LEAF_W-1:0]   up_leaf;
	logic [LEAF_W-1:0]   dn_leaf;
	logic [NWORDS-1:0]   up_sum;
	logic [NWORDS-1:0]   dn_sum;
	logic [FOUND_W-1:0]  found;
	logic                mem_we;
	logic [LEAF_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [WAW-1:0]      mem_raddr;
	logic                sum_set;
	logic                sum_clr;
	logic [WAW-1:0]      wi_d;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		if (size_q < SIZE_MIN) begin
			size_sat = SIZE_MIN;
		end else if (size_q > SIZE_W'(KEY_LIMIT_LOG2)) begin
			size_sat = SIZE_W'(KEY_LIMIT_LOG2);
		end else begin
			size_sat = size_q;
		end
		eff_log2 = (size_sat > SIZE_W'(EFF_MAX)) ? SIZE_W'(EFF_MAX) : size_sat;
	end

	assign limit    = (KEY_W + 1)'(1) << eff_log2;
	assign in_range = {1'b0, key_q} < limit;
	assign w        = key_q[BIT_W +: WAW];
	assign b        = key_q[BIT_W-1:0];
	assign bitm     = LEAF_W'(1) << b;
	assign word     = summary_q[w] ? rdata_q : '0;
	assign up_leaf  = word & (({LEAF_W{1'b1}} << b) << 1);
	assign dn_leaf  = word & (bitm - LEAF_W'(1));
	assign up_sum   = summary_q & (({NWORDS{1'b1}} << w) << 1);
	assign dn_sum   = summary_q & ((NWORDS'(1) << w) - NWORDS'(1));

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_wdata = word;
		mem_re    = 1'b0;
		mem_raddr = in_data.key[BIT_W +: WAW];
		sum_set   = 1'b0;
		sum_clr   = 1'b0;
		wi_d      = wi_q;
		found     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					mem_re  = 1'b1;
					state_d = S_LEAF;
				end
			end
			S_LEAF: begin
				res_d   = '{status: STAT_MISS, neighbor: '0};
				state_d = S_OUT;
				if (func_q > FN_PRED) begin
					res_d.status = STAT_MISS;
				end else if (!in_range) begin
					res_d.status = STAT_RANGE;
				end else begin
					case (func_q)
						FN_INS: begin
							mem_we       = 1'b1;
							mem_wdata    = word | bitm;
							sum_set      = 1'b1;
							res_d.status = STAT_OK;
						end
						FN_DEL: begin
							if ((word & bitm) != '0) begin
								mem_we       = 1'b1;
								mem_wdata    = word & ~bitm;
								sum_clr      = ((word & ~bitm) == '0);
								res_d.status = STAT_OK;
							end
						end
						FN_MEM: begin
							if ((word & bitm) != '0) res_d.status = STAT_OK;
						end
						FN_SUCC: begin
							if (up_leaf != '0) begin
								found = {w, low_leaf(up_leaf)};
								if ((KEY_W + 1)'(found) < limit) begin
									res_d.status   = STAT_OK;
									res_d.neighbor = KEY_W'(found);
								end
							end else if (up_sum != '0) begin
								wi_d      = low_sum(up_sum);
								mem_raddr = wi_d;
								mem_re    = 1'b1;
								state_d   = S_NEXT;
							end
						end
						FN_PRED: begin
							if (dn_leaf != '0) begin
								found          = {w, high_leaf(dn_leaf)};
								res_d.status   = STAT_OK;
								res_d.neighbor = KEY_W'(found);
							end else if (dn_sum != '0) begin
								wi_d      = high_sum(dn_sum);
								mem_raddr = wi_d;
								mem_re    = 1'b1;
								state_d   = S_NEXT;
							end
						end
						default: begin
							res_d.status = STAT_MISS;
						end
					endcase
				end
			end
			S_NEXT: begin
				state_d = S_OUT;
				res_d   = '{status: STAT_MISS, neighbor: '0};
				if (func_q == FN_SUCC) begin
					found = {wi_q, low_leaf(rdata_q)};
					if ((KEY_W + 1)'(found) < limit) begin
						res_d.status   = STAT_OK;
						res_d.neighbor = KEY_W'(found);
					end
				end else begin
					found          = {wi_q, high_leaf(rdata_q)};
					res_d.status   = STAT_OK;
					res_d.neighbor = KEY_W'(found);
				end
			end
			S_OUT: begin
				if (load_out) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[w] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= in_data.func;
			key_q  <= in_data.key;
		end
		wi_q  <= wi_d;
		res_q <= res_d;
		if (load_out) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SIZE_RESET;
			summary_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) size_q <= cfg_data;
			if (sum_set) summary_q[w] <= 1'b1;
			if (sum_clr) summary_q[w] <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/osss_check.sv
// ---------------------------------------------------------------------------
// osss_check
// Port-level checks of the ordered set block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module osss_check (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input osss_pkg::out_t out_data
);
	import osss_pkg::*;

	`OSSS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
	`OSSS_ASSERT(a_nb_zero, clk, arst_n, out_valid && out_data.status != STAT_OK |-> out_data.neighbor == '0, "neighbor set on a miss")
	`OSSS_NEVER(a_status, clk, arst_n, out_valid && out_data.status != STAT_OK && out_data.status != STAT_MISS && out_data.status != STAT_RANGE, "undefined status")
	`OSSS_ASSERT(a_single, clk, arst_n, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")

endmodule

bind ordered_integer_set_successor_top osss_check u_osss_check (.*);
